FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the wildcard matcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define WNM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define WNM_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WNM_ASSERT(lbl, clk, rst_n, prop, msg)
`define WNM_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/wnm_pkg.sv
// ----------------------------------------------------------------------------
// wnm_pkg
// Types, constants and helper functions of the wildcard name matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wnm_pkg;

	// Largest mask the register map can describe.
	localparam int MASK_MAX = 16;
	localparam int LEN_W    = 5;

	// Special mask bytes.
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_QMARK = 8'h3F;

	// Register reset values; the low word holds "*.*".
	localparam logic [63:0]      MASK_LO_RST  = 64'h0000_0000_002A_2E2A;
	localparam logic [63:0]      MASK_HI_RST  = 64'h0;
	localparam logic [LEN_W-1:0] MASK_LEN_RST = 5'd3;

	// Register indexes, taken from address bits 4:3.
	localparam logic [1:0] REG_MASK_LO  = 2'd0;
	localparam logic [1:0] REG_MASK_HI  = 2'd1;
	localparam logic [1:0] REG_MASK_LEN = 2'd2;

	// Per-cycle control broadcast to every cell of the row.
	typedef struct packed {
		logic accept;   // a transaction is taken this cycle
		logic restart;  // that transaction ends the name
	} wnm_ctrl_t;

	// Fold ASCII a-z to upper case; everything else is unchanged.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/wnm_star_cell.sv
// ----------------------------------------------------------------------------
// wnm_star_cell
// One link of the star closure chain: a reachable star position also makes
// the following position reachable.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_star_cell (
	input  wire logic act,        // position reachable before closure
	input  wire logic close_in,   // reached through a star on the left
	input  wire logic star,       // mask byte at this position is a star
	input  wire logic en,         // position lies inside the mask
	output logic      closed,     // position reachable after closure
	output logic      close_out   // passes reachability to the right
);

	assign closed    = act | close_in;
	assign close_out = closed & star & en;

endmodule

`default_nettype wire

FILE: design/wnm_cell.sv
// ----------------------------------------------------------------------------
// wnm_cell
// One mask position: holds its active bit, closes over stars and decides
// which position the current name byte reaches.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_cell
	import wnm_pkg::*;
#(
	parameter bit START = 1'b0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire wnm_ctrl_t  ctrl,
	input  wire logic [7:0] mask_byte,
	input  wire logic [7:0] name_fold,
	input  wire logic       en,
	input  wire logic       close_in,
	input  wire logic       take_in,
	output logic            act,
	output logic            nxt,
	output logic            close_out,
	output logic            take_out
);

	logic act_q;
	logic closed;
	logic star;
	logic hit;

	assign star = (mask_byte == CHAR_STAR);
	assign hit  = (mask_byte == CHAR_QMARK) || (fold_case(mask_byte) == name_fold);

	wnm_star_cell u_star (
		.act       (act_q),
		.close_in  (close_in),
		.star      (star),
		.en        (en),
		.closed    (closed),
		.close_out (close_out)
	);

	// A star keeps itself alive; any other match moves one to the right.
	assign nxt      = (closed & en & star) | take_in;
	assign take_out = closed & en & ~star & hit;
	assign act      = act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= START;
		end else if (ctrl.accept) begin
			act_q <= ctrl.restart ? START : nxt;
		end
	end

endmodule

`default_nettype wire

FILE: design/wnm_result.sv
// ----------------------------------------------------------------------------
// wnm_result
// Final star closure of an ended name and the registered match result.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_result #(
	parameter int N  = 16,
	parameter int LW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [N:0]    set_s1,
	input  wire logic          valid_s1,
	input  wire logic [N-1:0]  star_vec,
	input  wire logic [N-1:0]  en_vec,
	input  wire logic [LW-1:0] len_eff,
	input  wire logic          out_stall,
	output logic               adv_s1,
	output logic               out_valid,
	output logic               matched
);

	logic [N:0]   carry;
	logic [N-1:0] closed;
	logic [N:0]   closed_all;
	logic         out_valid_q;
	logic         matched_q;

	assign carry[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_close
		wnm_star_cell u_close (
			.act       (set_s1[i]),
			.close_in  (carry[i]),
			.star      (star_vec[i]),
			.en        (en_vec[i]),
			.closed    (closed[i]),
			.close_out (carry[i+1])
		);
	end

	assign closed_all = {set_s1[N] | carry[N], closed};

	// The result register takes a pending name whenever it is empty or being drained.
	assign adv_s1 = valid_s1 & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			matched_q <= closed_all[len_eff];
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

`default_nettype wire

FILE: design/wildcard_name_matcher_core.sv
// ----------------------------------------------------------------------------
// wildcard_name_matcher_core
// Case-insensitive wildcard matcher: a row of mask-position cells tracks the
// reachable positions of the mask while name bytes stream through.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_stall    name_byte, last_byte, empty_name
//   output    out        out_valid / out_stall  matched
//   config    in         APB psel/penable       paddr, pwdata -> prdata
//
// One name byte is taken every clock cycle while the input is not stalled: all cell
// positions update together while the star closure ripples along the row in the same
// cycle. After its last transaction a name passes through the final-closure stage and
// then the result register to its result. A stalled result holds the final-closure
// stage, and input stalls only while the stage is full and cannot drain.
// After reset only mask position zero is active and the mask reads "*.*".
//
`default_nettype none
`include "assert_macros.svh"

module wildcard_name_matcher_core
	import wnm_pkg::*;
#(
	parameter int MASK_CHARS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Name byte stream.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  name_byte,
	input  wire logic        last_byte,
	input  wire logic        empty_name,
	// Match results.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             matched,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int LW = $clog2(MASK_CHARS + 1);

	// ------------------------------------------------------------------
	// Configuration registers. The address bits above the word offset
	// select the register; writes to unmapped registers are dropped.
	// ------------------------------------------------------------------
	logic [63:0]      mask_lo_q;
	logic [63:0]      mask_hi_q;
	logic [LEN_W-1:0] mask_len_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_lo_q  <= MASK_LO_RST;
			mask_hi_q  <= MASK_HI_RST;
			mask_len_q <= MASK_LEN_RST;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_MASK_LO:  mask_lo_q  <= pwdata;
				REG_MASK_HI:  mask_hi_q  <= pwdata;
				REG_MASK_LEN: mask_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_MASK_LO:  prdata = mask_lo_q;
			REG_MASK_HI:  prdata = mask_hi_q;
			REG_MASK_LEN: prdata = {{(64-LEN_W){1'b0}}, mask_len_q};
			default:      prdata = 64'h0;
		endcase
	end

	// A length beyond the number of cells is clamped to the full row.
	logic [LW-1:0]         len_eff;
	logic [8*MASK_MAX-1:0] mask_all;

	assign len_eff  = (mask_len_q > LEN_W'(MASK_CHARS)) ? LW'(MASK_CHARS)
	                                                    : mask_len_q[LW-1:0];
	assign mask_all = {mask_hi_q, mask_lo_q};

	// ------------------------------------------------------------------
	// Input handshake and broadcast control.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic       adv_s1;
	logic       accept;
	logic       restart;
	wnm_ctrl_t  ctrl;
	logic [7:0] name_fold;

	// The final-closure stage is free when empty or when it drains now.
	assign in_stall  = valid_s1 & ~adv_s1;
	assign accept    = in_valid & ~in_stall;
	assign restart   = last_byte | empty_name;
	assign ctrl      = '{accept: accept, restart: restart};
	assign name_fold = fold_case(name_byte);

	// ------------------------------------------------------------------
	// Row of mask-position cells. Closure and take signals ripple from
	// position zero toward the end position.
	// ------------------------------------------------------------------
	logic [MASK_CHARS:0]   close_c;
	logic [MASK_CHARS:0]   take_c;
	logic [MASK_CHARS-1:0] act_vec;
	logic [MASK_CHARS-1:0] nxt_vec;
	logic [MASK_CHARS-1:0] star_vec;
	logic [MASK_CHARS-1:0] en_vec;
	logic                  act_end_q;

	assign close_c[0] = 1'b0;
	assign take_c[0]  = 1'b0;

	for (genvar i = 0; i < MASK_CHARS; i++) begin : g_cell
		assign star_vec[i] = (mask_all[8*i +: 8] == CHAR_STAR);
		assign en_vec[i]   = (len_eff > LW'(i));

		wnm_cell #(
			.START (i == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.mask_byte (mask_all[8*i +: 8]),
			.name_fold (name_fold),
			.en        (en_vec[i]),
			.close_in  (close_c[i]),
			.take_in   (take_c[i]),
			.act       (act_vec[i]),
			.nxt       (nxt_vec[i]),
			.close_out (close_c[i+1]),
			.take_out  (take_c[i+1])
		);
	end

	// The end position has no mask byte; it is only ever reached from the left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_end_q <= 1'b0;
		end else if (accept) begin
			act_end_q <= restart ? 1'b0 : take_c[MASK_CHARS];
		end
	end

	// ------------------------------------------------------------------
	// Final-closure stage. An empty-name transaction passes the stored
	// positions untouched, and the result stage closes them over stars.
	// ------------------------------------------------------------------
	logic [MASK_CHARS:0] set_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept & restart) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept & restart) begin
			set_s1 <= empty_name ? {act_end_q, act_vec} : {take_c[MASK_CHARS], nxt_vec};
		end
	end

	wnm_result #(
		.N  (MASK_CHARS),
		.LW (LW)
	) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_s1    (set_s1),
		.valid_s1  (valid_s1),
		.star_vec  (star_vec),
		.en_vec    (en_vec),
		.len_eff   (len_eff),
		.out_stall (out_stall),
		.adv_s1    (adv_s1),
		.out_valid (out_valid),
		.matched   (matched)
	);

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------

	// Ending a name leaves only the start position active.
	`WNM_ASSERT(a_restart_start, clk, arst_n,
		(accept & restart) |=> ({act_end_q, act_vec} == {{MASK_CHARS{1'b0}}, 1'b1}),
		"positions not reset to the start after a name ended")

	// Every ended name is queued for its final closure.
	`WNM_ASSERT(a_restart_queues, clk, arst_n,
		(accept & restart) |=> valid_s1,
		"ended name did not enter the final-closure stage")

	// A new result only appears after the final-closure stage held a name.
	`WNM_ASSERT(a_result_source, clk, arst_n,
		$rose(out_valid) |-> $past(valid_s1),
		"result produced without a pending name")

	// A full closure stage behind a stalled result must stall the input.
	`WNM_NEVER(a_no_overrun, clk, arst_n,
		valid_s1 & out_valid & out_stall & ~in_stall,
		"input accepted while the closure stage cannot drain")

endmodule

`default_nettype wire
